FILE: hdl/jcsf_pkg.sv
// Shared types, codes and helper functions for the coefficient symbol former.
package jcsf_pkg;

	// Number of color components with a DC predictor
	localparam int COMPONENTS = 3;
	localparam int COMP_IDX_W = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;

	// Symbol kinds
	localparam logic [1:0] KIND_DC  = 2'd0;
	localparam logic [1:0] KIND_AC  = 2'd1;
	localparam logic [1:0] KIND_ZRL = 2'd2;
	localparam logic [1:0] KIND_EOB = 2'd3;

	// Amplitude and run limits
	localparam logic signed [12:0] DIFF_MAX = 13'sd2047;
	localparam logic signed [12:0] DIFF_MIN = -13'sd2047;
	localparam logic signed [11:0] COEF_MIN = -12'sd2048;
	localparam logic signed [11:0] AC_MIN   = -12'sd2047;
	localparam logic [3:0] MAX_SIZE  = 4'd11;
	localparam logic [3:0] ZRL_RUN   = 4'd15;
	localparam logic [5:0] PEND_MAX  = 6'd63;
	localparam logic [5:0] LAST_POS  = 6'd63;
	localparam logic [7:0] ZRL_BYTE  = 8'hF0;
	localparam logic [7:0] EOB_BYTE  = 8'h00;

	// Command queue between front and back
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	// One classified item: kind, ZRLs to send first, run, saturated value
	typedef struct packed {
		logic [1:0]         kind;
		logic [1:0]         zrl;
		logic [3:0]         run;
		logic signed [11:0] value;
	} cmd_t;

	// Write side of the queue
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} push_t;

	// Head of the queue
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} head_t;

	// Magnitude of a value known to lie in -2047..2047
	function automatic logic [10:0] magnitude(input logic signed [11:0] v);
		logic [11:0] m;
		m = v[11] ? 12'(-v) : 12'(v);
		return m[10:0];
	endfunction

	// Size category: index of highest set bit plus one
	function automatic logic [3:0] size_of(input logic [10:0] mag);
		logic [3:0] s;
		s = 4'd0;
		for (int i = 0; i < 11; i++) begin
			if (mag[i]) s = 4'(i + 1);
		end
		return s;
	endfunction

	// Amplitude bits: magnitude, or its ones complement in size bits when negative
	function automatic logic [10:0] amp_of(input logic neg, input logic [10:0] mag,
		input logic [3:0] s);
		logic [10:0] mask;
		mask = 11'((12'd1 << s) - 12'd1);
		return neg ? (~mag & mask) : mag;
	endfunction

endpackage

FILE: hdl/jcsf_ifs.sv
// Valid/ready channel interfaces for coefficient input and symbol output.
interface jcsf_coef_if;
	logic               valid;
	logic               ready;
	logic signed [11:0] coefficient;
	logic [5:0]         position;
	logic [1:0]         color_component;

	modport source (output valid, output coefficient, output position,
		output color_component, input ready);
	modport sink (input valid, input coefficient, input position,
		input color_component, output ready);
endinterface

interface jcsf_sym_if;
	logic        valid;
	logic        ready;
	logic [1:0]  symbol_kind;
	logic [3:0]  zero_run;
	logic [3:0]  size_category;
	logic [10:0] amplitude_bits;
	logic [7:0]  symbol_byte;
	logic        last_of_run;

	modport source (output valid, output symbol_kind, output zero_run,
		output size_category, output amplitude_bits, output symbol_byte,
		output last_of_run, input ready);
	modport sink (input valid, input symbol_kind, input zero_run,
		input size_category, input amplitude_bits, input symbol_byte,
		input last_of_run, output ready);
endinterface

FILE: hdl/jpeg_coefficient_symbol_former.sv
// Top level of the coefficient symbol former: front end, command queue, back end.
//
//  channel  | dir | payload                                          | item
//  ---------+-----+--------------------------------------------------+---------------
//  coefs    | in  | coefficient, position, color_component           | one coefficient
//  symbols  | out | symbol_kind, zero_run, size_category,            | one symbol
//           |     | amplitude_bits, symbol_byte, last_of_run         |
//
// A coefficient is taken every cycle while the four-entry command queue has room.
// Each symbol is registered into the output from the command at the queue head; an AC item
// with pending ZRLs is sent as one ZRL symbol per pending ZRL, then the AC symbol.
// Sustained rate is one coefficient per cycle while symbols.ready is high, less while ZRLs are expanded.
// Reset clears the zero run count, the DC predictors, the queue and output valid.
// Output stalls fill the queue, then hold coefs.ready low.
module jpeg_coefficient_symbol_former (
	input logic          clk,
	input logic          arst_n,
	jcsf_coef_if.sink    coefs,
	jcsf_sym_if.source   symbols
);

	jcsf_pkg::push_t push;
	jcsf_pkg::head_t head;
	logic            q_full;
	logic            pop;

	jcsf_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (coefs.valid),
		.coefficient     (coefs.coefficient),
		.position        (coefs.position),
		.color_component (coefs.color_component),
		.q_full          (q_full),
		.in_ready        (coefs.ready),
		.push            (push)
	);

	jcsf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.full   (q_full),
		.head   (head)
	);

	jcsf_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.pop            (pop),
		.out_ready      (symbols.ready),
		.out_valid      (symbols.valid),
		.symbol_kind    (symbols.symbol_kind),
		.zero_run       (symbols.zero_run),
		.size_category  (symbols.size_category),
		.amplitude_bits (symbols.amplitude_bits),
		.symbol_byte    (symbols.symbol_byte),
		.last_of_run    (symbols.last_of_run)
	);

	// Only a ZRL leaves its item unfinished
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		symbols.valid |-> (symbols.last_of_run == (symbols.symbol_kind != jcsf_pkg::KIND_ZRL)))
		else $error("last_of_run does not match symbol kind");

	// ZRL and EOB carry no amplitude
	a_no_amp: assert property (@(posedge clk) disable iff (!arst_n)
		(symbols.valid && (symbols.symbol_kind == jcsf_pkg::KIND_ZRL ||
			symbols.symbol_kind == jcsf_pkg::KIND_EOB))
		|-> (symbols.size_category == 4'd0 && symbols.amplitude_bits == 11'd0))
		else $error("ZRL or EOB with nonzero size");

	// Size stays in range and the symbol byte agrees with run and size
	a_byte: assert property (@(posedge clk) disable iff (!arst_n)
		symbols.valid |-> (symbols.size_category <= jcsf_pkg::MAX_SIZE &&
			symbols.symbol_byte == {symbols.zero_run, symbols.size_category}))
		else $error("symbol byte or size out of line");

	// A full queue stalls the input side
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !coefs.ready)
		else $error("input taken while queue full");

endmodule

FILE: hdl/jcsf_front.sv
// Front end: accepts coefficients, tracks DC predictors and zero runs, classifies.
module jcsf_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic signed [11:0]  coefficient,
	input  logic [5:0]          position,
	input  logic [1:0]          color_component,
	input  logic                q_full,
	output logic                in_ready,
	output jcsf_pkg::push_t     push
);

	logic signed [11:0] pred_q [jcsf_pkg::COMPONENTS];
	logic [5:0]         pending_q;

	logic                                 accept;
	logic                                 comp_ok;
	logic [jcsf_pkg::COMP_IDX_W-1:0]      comp_idx;
	logic signed [11:0]                   pred;
	logic signed [12:0]                   diff;
	logic signed [11:0]                   diff_sat;
	logic signed [11:0]                   ac_val;
	logic                                 is_dc;
	logic                                 is_zero;
	logic                                 is_last;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign is_dc    = (position == 6'd0);
	assign is_zero  = (coefficient == 12'sd0);
	assign is_last  = (position == jcsf_pkg::LAST_POS);
	assign comp_ok  = (32'(color_component) < jcsf_pkg::COMPONENTS);
	assign comp_idx = jcsf_pkg::COMP_IDX_W'(color_component);

	// DC difference against the component predictor, saturated
	always_comb begin
		pred = comp_ok ? pred_q[comp_idx] : 12'sd0;
		diff = 13'(coefficient) - 13'(pred);
		if (diff > jcsf_pkg::DIFF_MAX)
			diff_sat = 12'(jcsf_pkg::DIFF_MAX);
		else if (diff < jcsf_pkg::DIFF_MIN)
			diff_sat = 12'(jcsf_pkg::DIFF_MIN);
		else
			diff_sat = diff[11:0];
		ac_val = (coefficient == jcsf_pkg::COEF_MIN) ? jcsf_pkg::AC_MIN : coefficient;
	end

	// Classify into a queue command
	always_comb begin
		push.valid     = accept && (is_dc || !is_zero || is_last);
		push.cmd.zrl   = pending_q[5:4];
		push.cmd.run   = pending_q[3:0];
		push.cmd.value = ac_val;
		push.cmd.kind  = jcsf_pkg::KIND_AC;
		if (is_dc) begin
			push.cmd.kind  = jcsf_pkg::KIND_DC;
			push.cmd.value = diff_sat;
		end else if (is_zero) begin
			push.cmd.kind  = jcsf_pkg::KIND_EOB;
		end
	end

	// Zero run count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 6'd0;
		end else if (accept) begin
			if (is_dc || !is_zero || is_last)
				pending_q <= 6'd0;
			else if (pending_q != jcsf_pkg::PEND_MAX)
				pending_q <= pending_q + 6'd1;
		end
	end

	// DC predictors take the new DC level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < jcsf_pkg::COMPONENTS; i++) pred_q[i] <= 12'sd0;
		end else if (accept && is_dc && comp_ok) begin
			pred_q[comp_idx] <= coefficient;
		end
	end

endmodule

FILE: hdl/jcsf_queue.sv
// Short command queue between the front and back ends.
module jcsf_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  jcsf_pkg::push_t     push,
	input  logic                pop,
	output logic                full,
	output jcsf_pkg::head_t     head
);

	jcsf_pkg::cmd_t                 slot_q [jcsf_pkg::QDEPTH];
	logic [jcsf_pkg::QPTR_W-1:0]    wr_q;
	logic [jcsf_pkg::QPTR_W-1:0]    rd_q;
	logic [jcsf_pkg::QCNT_W-1:0]    cnt_q;
	logic                           do_push;
	logic                           do_pop;

	assign full       = (cnt_q == jcsf_pkg::QCNT_W'(jcsf_pkg::QDEPTH));
	assign head.valid = (cnt_q != '0);
	assign head.cmd   = slot_q[rd_q];
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && head.valid;

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_q] <= push.cmd;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop)  rd_q <= rd_q + 1'b1;
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: hdl/jcsf_back.sv
// Back end: expands ZRLs, forms size/amplitude and drives the output register.
module jcsf_back (
	input  logic               clk,
	input  logic               arst_n,
	input  jcsf_pkg::head_t    head,
	output logic               pop,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [1:0]         symbol_kind,
	output logic [3:0]         zero_run,
	output logic [3:0]         size_category,
	output logic [10:0]        amplitude_bits,
	output logic [7:0]         symbol_byte,
	output logic               last_of_run
);

	logic [1:0]  zsent_q;
	logic        load;
	logic        send_zrl;
	logic [10:0] mag;
	logic [3:0]  size;
	logic [10:0] amp;

	assign load     = head.valid && (!out_valid || out_ready);
	assign send_zrl = (head.cmd.kind == jcsf_pkg::KIND_AC) && (zsent_q != head.cmd.zrl);
	assign pop      = load && !send_zrl;
	assign mag      = jcsf_pkg::magnitude(head.cmd.value);
	assign size     = jcsf_pkg::size_of(mag);
	assign amp      = jcsf_pkg::amp_of(head.cmd.value[11], mag, size);

	// ZRLs already sent for the head command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zsent_q <= 2'd0;
		end else if (load) begin
			zsent_q <= send_zrl ? zsent_q + 2'd1 : 2'd0;
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (load) begin
			if (send_zrl) begin
				symbol_kind    <= jcsf_pkg::KIND_ZRL;
				zero_run       <= jcsf_pkg::ZRL_RUN;
				size_category  <= 4'd0;
				amplitude_bits <= 11'd0;
				symbol_byte    <= jcsf_pkg::ZRL_BYTE;
				last_of_run    <= 1'b0;
			end else begin
				symbol_kind   <= head.cmd.kind;
				last_of_run   <= 1'b1;
				unique case (head.cmd.kind)
					jcsf_pkg::KIND_DC: begin
						zero_run       <= 4'd0;
						size_category  <= size;
						amplitude_bits <= amp;
						symbol_byte    <= {4'd0, size};
					end
					jcsf_pkg::KIND_AC: begin
						zero_run       <= head.cmd.run;
						size_category  <= size;
						amplitude_bits <= amp;
						symbol_byte    <= {head.cmd.run, size};
					end
					default: begin
						zero_run       <= 4'd0;
						size_category  <= 4'd0;
						amplitude_bits <= 11'd0;
						symbol_byte    <= jcsf_pkg::EOB_BYTE;
					end
				endcase
			end
		end
	end

endmodule
